/* hw/rtl/timestamped_ring_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped ring buffer
// Shared property shapes used by the checker.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_RING_BUFFER_ASSERT_SVH
`define TIMESTAMPED_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timestamped_ring_buffer: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timestamped_ring_buffer: next-cycle property failed");

`endif

/* hw/rtl/trb_pkg.sv */
// ----------------------------------------------------------------------------
// trb_pkg
// Types, sizes and codes shared by the timestamped ring buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trb_pkg;

  localparam int unsigned Depth        = 64;
  localparam int unsigned PayloadWidth = 32;
  localparam int unsigned StampWidth   = 64;
  localparam int unsigned IdxW         = $clog2(Depth);
  localparam int unsigned CntW         = $clog2(Depth + 1);
  localparam int unsigned RsW          = 7;
  localparam int unsigned WideW        = (CntW > RsW) ? CntW : RsW;
  localparam int unsigned EntryW       = StampWidth + PayloadWidth;

  localparam logic [RsW-1:0] RingSizeReset = 7'd64;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqRead   = 2'd1;
  localparam logic [1:0] ReqFind   = 2'd2;

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StOrder     = 4'd1,
    StBeyond    = 4'd2,
    StNotFilled = 4'd3,
    StBadStamp  = 4'd4,
    StTooFew    = 4'd5,
    StTooNew    = 4'd6,
    StTooOld    = 4'd7,
    StNotFound  = 4'd8
  } trb_status_e;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [StampWidth-1:0] stamp;
    logic [31:0]                  payload_in;
    logic [5:0]                   age_position;
  } trb_req_t;

  typedef struct packed {
    logic [3:0]                   status;
    logic signed [StampWidth-1:0] stamp_out;
    logic [31:0]                  payload_out;
  } trb_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        cfg_wr;
    logic        insert;
    logic        rd_age;
    logic        rd_oldest;
    logic        walk_start;
    logic        walk_step;
    logic        emit;
    logic        emit_data;
    trb_status_e emit_status;
  } trb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       ins_ok;
    logic       rd_beyond;
    logic       rd_notfilled;
    logic       fd_bad;
    logic       fd_toofew;
    logic       fd_toonew;
    logic       too_old;
    logic       match;
    logic       walk_last;
  } trb_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/timestamped_ring_buffer.sv */
// ----------------------------------------------------------------------------
// timestamped_ring_buffer
// Ring of stamped entries with insert, read by age and find by timestamp.
// ----------------------------------------------------------------------------
//
//   channel   signals                                 transaction when
//   --------  --------------------------------------  ---------------------------
//   request   start, busy, req_i                      start && !busy
//   result    done_o, rsp_o                           done_o (one cycle, no stall)
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i    cfg_valid_i && cfg_ready_o
//
// Steps: insert, type-three and early-reject requests end in the decode
// step; a read by age adds a memory read step; a find that passes the early
// checks reads the oldest entry, then walks from the newest back. The walk reads
// one entry per cycle through the single read port of the entry memory.
// The result shows in the first cycle after busy drops, and the next request
// may be taken in that same cycle. Results cannot be held off.
// Reset: ring empty, size Depth, last stamp 0; no clearing pass is needed.
// A size write empties the ring and is taken only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_ring_buffer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request
  input  wire logic              start,
  output logic                   busy,
  input  wire trb_pkg::trb_req_t req_i,
  // result
  output logic                   done_o,
  output trb_pkg::trb_rsp_t      rsp_o,
  // size register write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [6:0]        cfg_data_i
);

  import trb_pkg::*;

  trb_cmd_t cmd;
  trb_sts_t sts;

  // Sequencer: decides each step from the datapath flags.
  trb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: hold ring state and entries, compare stamps, register result.
  trb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o),
    .done_o     (done_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/trb_ram.sv */
// ----------------------------------------------------------------------------
// trb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/trb_ctrl.sv */
// ----------------------------------------------------------------------------
// trb_ctrl
// Request sequencer: decode, memory read, oldest-entry check and walk.
// ----------------------------------------------------------------------------
`default_nettype none

module trb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire trb_pkg::trb_sts_t sts_i,
  output trb_pkg::trb_cmd_t      cmd_o
);

  import trb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_OLDEST,
    S_WALK
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_status = StNotFound;
    case (state_q)
      S_IDLE: begin
        cmd_o.cfg_wr = cfg_valid_i;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (sts_i.req_type)
          ReqInsert: begin
            cmd_o.insert      = sts_i.ins_ok;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = sts_i.ins_ok ? StOk : StOrder;
          end
          ReqRead: begin
            if (sts_i.rd_beyond) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = StBeyond;
            end else if (sts_i.rd_notfilled) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = StNotFilled;
            end else begin
              cmd_o.rd_age = 1'b1;
              state_d      = S_READ;
            end
          end
          ReqFind: begin
            if (sts_i.fd_bad) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = StBadStamp;
            end else if (sts_i.fd_toofew) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = StTooFew;
            end else if (sts_i.fd_toonew) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = StTooNew;
            end else begin
              cmd_o.rd_oldest = 1'b1;
              state_d         = S_OLDEST;
            end
          end
          default: begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = StNotFound;
          end
        endcase
      end
      S_READ: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_data   = 1'b1;
        cmd_o.emit_status = StOk;
        state_d           = S_IDLE;
      end
      S_OLDEST: begin
        if (sts_i.too_old) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StTooOld;
          state_d           = S_IDLE;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.match) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_data   = 1'b1;
          cmd_o.emit_status = StOk;
          state_d           = S_IDLE;
        end else if (sts_i.walk_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StNotFound;
          state_d           = S_IDLE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/trb_dp.sv */
// ----------------------------------------------------------------------------
// trb_dp
// Ring state, entry memory, request checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trb_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire trb_pkg::trb_req_t req_i,
  input  wire logic [6:0]        cfg_data_i,
  input  wire trb_pkg::trb_cmd_t cmd_i,
  output trb_pkg::trb_sts_t      sts_o,
  output trb_pkg::trb_rsp_t      rsp_o,
  output logic                   done_o
);

  import trb_pkg::*;

  // Slot holding the entry pos steps back from the newest (pos < size).
  function automatic logic [IdxW-1:0] slot_back(input logic [CntW-1:0] pos,
                                                input logic [CntW-1:0] size,
                                                input logic [IdxW-1:0] newest);
    logic [CntW:0] n;
    logic [CntW:0] r;
    n = (CntW + 1)'(newest);
    if ((CntW + 1)'(pos) <= n) begin
      r = n - (CntW + 1)'(pos);
    end else begin
      r = n + (CntW + 1)'(size) - (CntW + 1)'(pos);
    end
    return r[IdxW-1:0];
  endfunction

  trb_req_t                     req_q;
  logic [RsW-1:0]               rs_q;
  logic [IdxW-1:0]              newest_q;
  logic [CntW-1:0]              fill_q;
  logic signed [StampWidth-1:0] last_q;
  logic [IdxW-1:0]              idx_q;
  logic [CntW-1:0]              cnt_q;
  trb_rsp_t                     rsp_q;
  logic                         done_q;

  logic [WideW-1:0]             rs_wide;
  logic [WideW-1:0]             size_wide;
  logic [CntW-1:0]              size;
  logic [WideW-1:0]             pos_wide;
  logic [IdxW-1:0]              next_slot;
  logic [IdxW-1:0]              prev_slot;
  logic [IdxW-1:0]              raddr;
  logic                         re;
  logic [EntryW-1:0]            wdata;
  logic [EntryW-1:0]            rdata;
  logic signed [StampWidth-1:0] rd_stamp;
  logic [PayloadWidth-1:0]      rd_payload;

  // Clamp the configured size into 1..Depth.
  assign rs_wide = WideW'(rs_q);
  always_comb begin
    if (rs_wide == '0) begin
      size_wide = WideW'(1);
    end else if (rs_wide > WideW'(Depth)) begin
      size_wide = WideW'(Depth);
    end else begin
      size_wide = rs_wide;
    end
  end
  assign size     = size_wide[CntW-1:0];
  assign pos_wide = WideW'(req_q.age_position);

  always_comb begin
    if (fill_q == '0) begin
      next_slot = '0;
    end else if ((CntW + 1)'(newest_q) + (CntW + 1)'(1) >= (CntW + 1)'(size)) begin
      next_slot = '0;
    end else begin
      next_slot = newest_q + IdxW'(1);
    end
  end

  always_comb begin
    if (idx_q == '0) begin
      prev_slot = IdxW'(size - CntW'(1));
    end else begin
      prev_slot = idx_q - IdxW'(1);
    end
  end

  always_comb begin
    raddr = prev_slot;
    if (cmd_i.rd_age) begin
      raddr = slot_back(pos_wide[CntW-1:0], size, newest_q);
    end else if (cmd_i.rd_oldest) begin
      raddr = slot_back(fill_q - CntW'(1), size, newest_q);
    end else if (cmd_i.walk_start) begin
      raddr = newest_q;
    end
  end
  assign re    = cmd_i.rd_age | cmd_i.rd_oldest | cmd_i.walk_start | cmd_i.walk_step;
  assign wdata = {req_q.stamp, req_q.payload_in[PayloadWidth-1:0]};

  trb_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (next_slot),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_stamp   = rdata[EntryW-1 -: StampWidth];
  assign rd_payload = rdata[PayloadWidth-1:0];

  always_comb begin
    sts_o              = '0;
    sts_o.req_type     = req_q.req_type;
    sts_o.ins_ok       = (req_q.stamp > last_q);
    sts_o.rd_beyond    = (pos_wide >= size_wide);
    sts_o.rd_notfilled = (pos_wide >= WideW'(fill_q));
    sts_o.fd_bad       = (req_q.stamp <= $signed(StampWidth'(0)));
    sts_o.fd_toofew    = (fill_q < CntW'(2));
    sts_o.fd_toonew    = (req_q.stamp > last_q);
    sts_o.too_old      = (req_q.stamp < rd_stamp);
    sts_o.match        = (req_q.stamp == rd_stamp);
    sts_o.walk_last    = (cnt_q == CntW'(1));
  end

  // Request capture and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.walk_start) begin
      idx_q <= newest_q;
      cnt_q <= fill_q;
    end else if (cmd_i.walk_step) begin
      idx_q <= prev_slot;
      cnt_q <= cnt_q - CntW'(1);
    end
    if (cmd_i.emit) begin
      rsp_q.status      <= cmd_i.emit_status;
      rsp_q.stamp_out   <= cmd_i.emit_data ? rd_stamp : '0;
      rsp_q.payload_out <= cmd_i.emit_data ? 32'(rd_payload) : '0;
    end
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q     <= RingSizeReset;
      newest_q <= '0;
      fill_q   <= '0;
      last_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.cfg_wr) begin
        rs_q     <= cfg_data_i;
        newest_q <= '0;
        fill_q   <= '0;
        last_q   <= '0;
      end else if (cmd_i.insert) begin
        newest_q <= next_slot;
        last_q   <= req_q.stamp;
        if (fill_q < size) begin
          fill_q <= fill_q + CntW'(1);
        end
      end
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hw/rtl/trb_checker.sv */
// ----------------------------------------------------------------------------
// trb_port_checker
// Port-level properties of the timestamped ring buffer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timestamped_ring_buffer_assert.svh"

module trb_port_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire trb_pkg::trb_rsp_t rsp_o
);

  import trb_pkg::*;

  // An accepted request always makes the block busy in the cycle after.
  `TRB_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // A result is shown only once the sequencer is back to idle.
  `TRB_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // Results never come back to back.
  `TRB_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // Failed requests return zero stamp and payload.
  `TRB_ASSERT_IMP(a_err_zero, clk_i, rst_ni, done_o && (rsp_o.status != StOk),
                  (rsp_o.stamp_out == '0) && (rsp_o.payload_out == '0))

endmodule

bind timestamped_ring_buffer trb_port_checker u_trb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire

/* verif/trb_checker.sv */
// ----------------------------------------------------------------------------
// trb_checker
// Watches the request, result and size-write channels of the timestamped
// ring buffer, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module trb_checker
  import trb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  trb_req_t    req_i,
  input  logic        done_o,
  input  trb_rsp_t    rsp_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [StampWidth-1:0] ring_stamp [Depth];
  logic [31:0]                  ring_payload [Depth];
  int unsigned                  newest_idx;
  int unsigned                  filled;
  logic signed [StampWidth-1:0] latest_stamp;
  logic [6:0]                   size_reg;

  trb_rsp_t    expected_rsp_q [$];
  trb_rsp_t    want_rsp;
  trb_rsp_t    pred_rsp;
  int unsigned mismatches = 0;

  function automatic int unsigned active_size();
    if (size_reg < 7'd1) return 1;
    if (size_reg > Depth) return Depth;
    return 32'(size_reg);
  endfunction

  // Slot that lies pos entries back from the newest one.
  function automatic int unsigned slot_back(int unsigned pos, int unsigned size);
    if (pos <= newest_idx) return (newest_idx - pos) % Depth;
    return (newest_idx + size - pos) % Depth;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] trb_checker: %s", $time, msg);
  endtask

  // Advance the ring state by one request and produce its result.
  task automatic lookup_or_insert(input trb_req_t rq, output trb_rsp_t rs);
    int unsigned                  size;
    int unsigned                  nx;
    int unsigned                  k;
    logic signed [StampWidth-1:0] ts;
    trb_status_e                  st;
    logic signed [StampWidth-1:0] so;
    logic [31:0]                  po;
    bit                           hit;
    size = active_size();
    ts   = $signed(rq.stamp);
    st   = StNotFound;
    so   = '0;
    po   = '0;
    hit  = 1'b0;
    case (rq.req_type)
      ReqInsert: begin
        if (ts <= latest_stamp) begin
          st = StOrder;
        end else begin
          nx = 0;
          if (filled != 0) begin
            nx = newest_idx + 1;
            if (nx >= size) nx = 0;
          end
          nx = nx % Depth;
          ring_stamp[nx]   = ts;
          ring_payload[nx] = rq.payload_in;
          newest_idx       = nx;
          if (filled < size) filled++;
          latest_stamp = ts;
          st = StOk;
        end
      end
      ReqRead: begin
        if (rq.age_position >= size) begin
          st = StBeyond;
        end else if (rq.age_position >= filled) begin
          st = StNotFilled;
        end else begin
          k  = slot_back(32'(rq.age_position), size);
          so = ring_stamp[k];
          po = ring_payload[k];
          st = StOk;
        end
      end
      ReqFind: begin
        if (ts <= 0) begin
          st = StBadStamp;
        end else if (filled < 2) begin
          st = StTooFew;
        end else if (ts > latest_stamp) begin
          st = StTooNew;
        end else if (ts < ring_stamp[slot_back(filled - 1, size)]) begin
          st = StTooOld;
        end else begin
          // walk newest to oldest, keep the first exact match
          for (int unsigned i = 0; i < filled; i++) begin
            k = slot_back(i, size);
            if (!hit && ring_stamp[k] == ts) begin
              hit = 1'b1;
              so  = ring_stamp[k];
              po  = ring_payload[k];
              st  = StOk;
            end
          end
        end
      end
      default: st = StNotFound;
    endcase
    rs.status      = st;
    rs.stamp_out   = so;
    rs.payload_out = po;
  endtask

  task automatic compare_rsp(input trb_rsp_t got, input trb_rsp_t want);
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.stamp_out !== want.stamp_out)
      report($sformatf("stamp_out got %0h want %0h", got.stamp_out, want.stamp_out));
    if (got.payload_out !== want.payload_out)
      report($sformatf("payload_out got %0h want %0h", got.payload_out, want.payload_out));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        ring_stamp[i]   = '0;
        ring_payload[i] = '0;
      end
      newest_idx   = 0;
      filled       = 0;
      latest_stamp = '0;
      size_reg     = RingSizeReset;
      expected_rsp_q.delete();
      pending_o   <= 0;
      err_count_o <= mismatches;
    end else begin
      // retire the result first: it belongs to an earlier transaction
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          compare_rsp(rsp_o, want_rsp);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        size_reg     = cfg_data_i;
        filled       = 0;
        newest_idx   = 0;
        latest_stamp = '0;
      end
      if (start && !busy) begin
        lookup_or_insert(req_i, pred_rsp);
        expected_rsp_q.push_back(pred_rsp);
      end
      pending_o   <= expected_rsp_q.size();
      err_count_o <= mismatches;
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the timestamped ring buffer with a directed opening and random
// phases under several ring sizes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb
  import trb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code with no meaning, answered as not found.
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned PhaseItems = 143;
  // Worst result latency: a find walking the full ring.
  localparam int unsigned TailCycles = Depth + 8;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  trb_req_t    req_d     = '0;
  logic        done_o;
  trb_rsp_t    rsp_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data  = '0;
  int unsigned fail_count;
  int unsigned pending;

  // Stimulus shaping state: last good stamp sent and the stamps stored.
  longint      top_stamp;
  longint      sent_stamps [$];
  int unsigned ring_len;
  int unsigned burst_left;

  timestamped_ring_buffer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_d),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  trb_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_d),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .err_count_o(fail_count),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic trb_req_t mk_req(logic [1:0] kind, longint ts, logic [31:0] pay,
                                      logic [5:0] pos);
    trb_req_t rq;
    rq.req_type     = kind;
    rq.stamp        = ts;
    rq.payload_in   = pay;
    rq.age_position = pos;
    return rq;
  endfunction

  // Idle a random number of cycles, then hold start until the transaction
  // is taken. Leave start high so back-to-back requests need no toggle.
  task automatic send_req(input trb_req_t rq);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_d <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write the ring size while idle; the write also empties the ring.
  task automatic write_size(input logic [6:0] sz);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    top_stamp = 0;
    sent_stamps.delete();
    ring_len = (sz < 1) ? 1 : ((sz > Depth) ? Depth : sz);
  endtask

  // Mostly well-formed traffic: rising stamps, finds aimed at stored
  // entries, reads within the ring; the rest is noise.
  task automatic gen_item(input int unsigned ins_pct, output trb_req_t rq);
    int unsigned roll;
    int unsigned sub;
    int unsigned back;
    longint      ts;
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    ts   = {$urandom, $urandom};
    rq   = mk_req(ReqUnused, ts, $urandom, 6'($urandom_range(0, 63)));
    if (roll < ins_pct) begin
      rq.req_type = ReqInsert;
      if (sub < 85) begin
        if (sent_stamps.size() == 0 && $urandom_range(0, 3) == 0)
          ts = {2'b00, ts[61:0]};
        else if ($urandom_range(0, 9) == 0)
          ts = top_stamp + longint'($urandom) + 1;
        else
          ts = top_stamp + $urandom_range(1, 20);
        top_stamp = ts;
        sent_stamps.push_back(ts);
        if (sent_stamps.size() > Depth + 16) void'(sent_stamps.pop_front());
      end else if (sub < 93) begin
        ts = top_stamp - $urandom_range(0, 5);
      end else begin
        ts[63] = 1'b1;
      end
      rq.stamp = ts;
    end else if (roll < ins_pct + 25) begin
      rq.req_type = ReqRead;
      if (sub < 80) rq.age_position = 6'($urandom_range(0, ring_len - 1));
    end else if (roll < 97) begin
      rq.req_type = ReqFind;
      if (sub < 55 && sent_stamps.size() > 0) begin
        back = $urandom_range(0, ring_len + 1);
        if (back >= sent_stamps.size()) back = sent_stamps.size() - 1;
        rq.stamp = sent_stamps[sent_stamps.size() - 1 - back];
      end else if (sub < 65 && sent_stamps.size() > 0) begin
        rq.stamp = sent_stamps[$urandom_range(0, sent_stamps.size() - 1)] + 1;
      end else if (sub < 75) begin
        rq.stamp = top_stamp + $urandom_range(1, 50);
      end else if (sub < 85) begin
        rq.stamp = (sent_stamps.size() > 0) ? sent_stamps[0] - 1 : 1;
      end else if (sub < 95) begin
        rq.stamp = ($urandom_range(0, 1) == 0) ? 0 : {1'b1, ts[62:0]};
      end
    end
  endtask

  initial begin
    trb_req_t    rq;
    logic [6:0]  sizes [10];
    top_stamp  = 0;
    ring_len   = Depth;
    burst_left = 0;
    sizes = '{7'd1, 7'd0, 7'd2, 7'd127, 7'd64, 7'd3, 7'd0, 7'd5, 7'd0, 7'd64};
    sizes[6] = 7'($urandom_range(1, 70));
    sizes[8] = 7'($urandom_range(1, 70));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset size: empty ring, ordering, every
    // find rejection, hits at both ends, reads past the fill, extremes.
    send_req(mk_req(ReqFind,   64'h8000_0000_0000_0000, 32'h0, 6'd0));
    send_req(mk_req(ReqRead,   0,                       32'h0, 6'd0));
    send_req(mk_req(ReqInsert, 0,                       32'h1234_5678, 6'd0));
    send_req(mk_req(ReqInsert, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 6'd63));
    send_req(mk_req(ReqFind,   5,                       32'h0, 6'd0));
    send_req(mk_req(ReqInsert, 100,                     32'h0000_0000, 6'd0));
    send_req(mk_req(ReqFind,   100,                     32'h0, 6'd0));
    send_req(mk_req(ReqInsert, 100,                     32'hDEAD_BEEF, 6'd0));
    send_req(mk_req(ReqInsert, 200,                     32'hFFFF_FFFF, 6'd0));
    send_req(mk_req(ReqInsert, 300,                     32'hA5A5_5A5A, 6'd0));
    send_req(mk_req(ReqFind,   400,                     32'h0, 6'd0));
    send_req(mk_req(ReqFind,   50,                      32'h0, 6'd0));
    send_req(mk_req(ReqFind,   150,                     32'h0, 6'd0));
    send_req(mk_req(ReqFind,   200,                     32'h0, 6'd0));
    send_req(mk_req(ReqFind,   100,                     32'h0, 6'd0));
    send_req(mk_req(ReqFind,   300,                     32'h0, 6'd0));
    send_req(mk_req(ReqRead,   0,                       32'h0, 6'd0));
    send_req(mk_req(ReqRead,   0,                       32'h0, 6'd2));
    send_req(mk_req(ReqRead,   0,                       32'h0, 6'd3));
    send_req(mk_req(ReqUnused, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
    send_req(mk_req(ReqInsert, 64'h7FFF_FFFF_FFFF_FFFF, 32'h5555_AAAA, 6'd0));
    send_req(mk_req(ReqFind,   64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 6'd0));
    send_req(mk_req(ReqInsert, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 6'd0));
    send_req(mk_req(ReqRead,   0,                       32'h0, 6'd63));
    send_req(mk_req(ReqFind,   0,                       32'h0, 6'd0));

    // Random phases, one per ring size; bigger rings get more inserts
    // so they fill and wrap.
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        gen_item((ring_len >= 32) ? 60 : 45, rq);
        send_req(rq);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* timestamped_ring_buffer.f */
+incdir+hw/rtl
hw/rtl/trb_pkg.sv
hw/rtl/trb_ram.sv
hw/rtl/trb_ctrl.sv
hw/rtl/trb_dp.sv
hw/rtl/timestamped_ring_buffer.sv
hw/rtl/trb_checker.sv
verif/trb_checker.sv
verif/tb.sv
